>>> rtl/hsj_pkg.sv
// Shared constants and types for the Halton sub-pixel jitter block.
// Depends on nothing; used by hsj_div, halton_subpixel_jitter, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hsj_pkg;

    localparam int PHASE_W  = 9;
    localparam int DIM_W    = 15;
    localparam int FRAME_W  = 64;
    localparam int PIX_W    = 16;
    localparam int NDC_W    = 18;
    localparam int IDX_W    = 9;
    localparam int NUM3_W   = 10;

    localparam int MAX_PHASES = 256;

    // frame index is reduced two bits per cycle
    localparam int MOD_STEPS = FRAME_W / 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    // shared divider: 18 quotient bits, two per cycle
    localparam int DIV_Q_W   = 18;
    localparam int DIV_STEPS = DIV_Q_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PHASE_W-1:0] PHASE_RST  = 9'd8;
    localparam logic [DIM_W-1:0]   WIDTH_RST  = 15'd1920;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 15'd1080;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_PHASE_COUNT = 2'd0;
    localparam logic [1:0] REG_VP_WIDTH    = 2'd1;
    localparam logic [1:0] REG_VP_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0]   rem_init;
        logic [DIV_Q_W-1:0] dividend;
        logic [DIM_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/hsj_div.sv
// Radix-4 restoring divider, two quotient bits per cycle.
// Depends on hsj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsj_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire hsj_pkg::div_req_t         req,
    output hsj_pkg::div_stat_t             stat,
    output logic [hsj_pkg::DIV_Q_W-1:0]    quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [hsj_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [hsj_pkg::DIM_W-1:0]     rem_reg, rem_next;
    logic [hsj_pkg::DIV_Q_W-1:0]   q_reg, q_next;
    logic [hsj_pkg::DIM_W-1:0]     div_reg, div_next;

    logic [hsj_pkg::DIM_W-1:0]     r_step;
    logic [hsj_pkg::DIV_Q_W-1:0]   q_step;
    logic [hsj_pkg::DIM_W:0]       r2;
    logic                          ge;

    // two dependent restoring steps per cycle
    always_comb
    begin
        r_step = rem_reg;
        q_step = q_reg;
        r2     = '0;
        ge     = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            r2     = {r_step, q_step[hsj_pkg::DIV_Q_W-1]};
            ge     = (r2 >= {1'b0, div_reg});
            r_step = ge ? hsj_pkg::DIM_W'(r2 - {1'b0, div_reg})
                        : hsj_pkg::DIM_W'(r2);
            q_step = {q_step[hsj_pkg::DIV_Q_W-2:0], ge};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.rem_init;
            q_next    = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = r_step;
            q_next   = q_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hsj_pkg::DIV_CNT_W'(hsj_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

>>> rtl/halton_subpixel_jitter.sv
// Halton (base 2 / base 3) sub-pixel jitter with NDC offsets.
// Depends on hsj_pkg and hsj_div.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       s_tdata: frame_index
//  m_*       out  m_tvalid / m_tready       m_tdata: pixel_x, pixel_y, ndc_x, ndc_y
//                                           m_tuser: bad_viewport
//  apb       in   psel/penable, pready=1    phase_count, viewport_width, viewport_height
//
// One request in flight. A normal request runs through the 2-bit-per-cycle modulo
// loop, base-3 digit extraction, then three passes through the shared divider.
// Empty viewport or zero phase count: straight from idle to the done state.
// s_tready is high only while idle; a finished result sits in the output
// register, so the next request is taken while m_tready is low.
// rst_n is asynchronous; control and configuration registers reset, datapath ones do not.
`timescale 1ns / 1ps
`default_nettype none

module halton_subpixel_jitter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request: [63:0] frame_index
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    // result: [15:0] pixel_x, [31:16] pixel_y, [49:32] ndc_x, [67:50] ndc_y,
    //         [71:68] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    // result: [0] bad_viewport
    output logic [0:0]       m_tuser,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_DIG  = 3'd2;
    localparam logic [2:0] S_RI3  = 3'd3;
    localparam logic [2:0] S_NX   = 3'd4;
    localparam logic [2:0] S_NY   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // ---------------- configuration registers ----------------
    logic [hsj_pkg::PHASE_W-1:0] phase_count_reg;
    logic [hsj_pkg::DIM_W-1:0]   vp_width_reg;
    logic [hsj_pkg::DIM_W-1:0]   vp_height_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= hsj_pkg::PHASE_RST;
            vp_width_reg    <= hsj_pkg::WIDTH_RST;
            vp_height_reg   <= hsj_pkg::HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                hsj_pkg::REG_PHASE_COUNT: phase_count_reg <= pwdata[hsj_pkg::PHASE_W-1:0];
                hsj_pkg::REG_VP_WIDTH:    vp_width_reg    <= pwdata[hsj_pkg::DIM_W-1:0];
                hsj_pkg::REG_VP_HEIGHT:   vp_height_reg   <= pwdata[hsj_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            hsj_pkg::REG_PHASE_COUNT: prdata = {23'd0, phase_count_reg};
            hsj_pkg::REG_VP_WIDTH:    prdata = {17'd0, vp_width_reg};
            hsj_pkg::REG_VP_HEIGHT:   prdata = {17'd0, vp_height_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- datapath state ----------------
    logic [2:0]                    state_reg, state_next;
    logic [hsj_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    logic [hsj_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [hsj_pkg::PHASE_W-1:0]   phases_reg, phases_next;
    logic [hsj_pkg::PHASE_W-1:0]   rem_reg, rem_next;
    logic [hsj_pkg::IDX_W-1:0]     t_reg, t_next;
    logic [hsj_pkg::NUM3_W-1:0]    num_reg, num_next;
    logic [hsj_pkg::NUM3_W-1:0]    den_reg, den_next;
    logic [hsj_pkg::PIX_W-1:0]     px_reg, px_next;
    logic [hsj_pkg::PIX_W-1:0]     py_reg, py_next;
    logic [hsj_pkg::NDC_W-1:0]     nx_reg, nx_next;
    logic [hsj_pkg::NDC_W-1:0]     ny_reg, ny_next;
    logic                          bad_reg, bad_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [hsj_pkg::PIX_W-1:0]     o_px_reg, o_py_reg;
    logic [hsj_pkg::NDC_W-1:0]     o_nx_reg, o_ny_reg;
    logic                          o_bad_reg;
    logic                          out_load;

    logic                          s_acc;
    logic [hsj_pkg::PHASE_W-1:0]   phases_c;
    logic [hsj_pkg::PHASE_W-1:0]   rem_step;
    logic [hsj_pkg::PHASE_W:0]     rem2;
    logic                          rem_ge;
    logic [hsj_pkg::IDX_W-1:0]     idx_c;
    logic [hsj_pkg::PIX_W-1:0]     px_c;
    logic [18:0]                   prod3;
    logic [hsj_pkg::IDX_W-1:0]     t_div3;
    logic [1:0]                    digit;

    logic                          div_start;
    hsj_pkg::div_req_t             div_req;
    hsj_pkg::div_stat_t            div_stat;
    logic [hsj_pkg::DIV_Q_W-1:0]   div_q;

    // |2*v| for a signed 16-bit v, as an 18-bit dividend
    function automatic logic [hsj_pkg::DIV_Q_W-1:0] mag2(input logic [hsj_pkg::PIX_W-1:0] v);
        logic [hsj_pkg::PIX_W:0] a;
        a = v[hsj_pkg::PIX_W-1] ? ((hsj_pkg::PIX_W+1)'(0) - {1'b1, v}) : {1'b0, v};
        return {a, 1'b0};
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // saturate phase count to the supported cycle length
    assign phases_c = ({23'd0, phase_count_reg} > 32'(hsj_pkg::MAX_PHASES))
                      ? hsj_pkg::PHASE_W'(hsj_pkg::MAX_PHASES) : phase_count_reg;

    // modulo: two frame bits per cycle, MSB first
    always_comb
    begin
        rem_step = rem_reg;
        rem2     = '0;
        rem_ge   = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            rem2     = {rem_step, frame_reg[hsj_pkg::FRAME_W-1-k]};
            rem_ge   = (rem2 >= {1'b0, phases_reg});
            rem_step = rem_ge ? hsj_pkg::PHASE_W'(rem2 - {1'b0, phases_reg})
                              : hsj_pkg::PHASE_W'(rem2);
        end
    end

    // remainder < phases <= 256, so the +1 stays in 9 bits
    assign idx_c = hsj_pkg::IDX_W'(rem_step + 1'b1);

    // base-2 radical inverse is the bit-reversed index; minus one half flips the MSB
    always_comb
    begin
        px_c = '0;
        for (int i = 0; i < hsj_pkg::IDX_W; i++)
            px_c[hsj_pkg::PIX_W-1-i] = idx_c[i];
        px_c[hsj_pkg::PIX_W-1] = ~px_c[hsj_pkg::PIX_W-1];
    end

    // t/3 by reciprocal: exact for t < 512
    assign prod3  = 19'(t_reg) * 19'd683;
    assign t_div3 = hsj_pkg::IDX_W'(prod3[18:11]);
    assign digit  = 2'(t_reg - hsj_pkg::IDX_W'({t_div3, 1'b0} + t_div3));

    // divider operands, chosen by the state that launches the pass
    always_comb
    begin
        div_req = '0;
        unique case (state_reg)
            S_DIG:
            begin
                div_req.rem_init = hsj_pkg::DIM_W'(num_reg);
                div_req.divisor  = hsj_pkg::DIM_W'(den_reg);
            end
            S_RI3:
            begin
                div_req.dividend = mag2(px_reg);
                div_req.divisor  = vp_width_reg;
            end
            S_NX:
            begin
                div_req.dividend = mag2(py_reg);
                div_req.divisor  = vp_height_reg;
            end
            default: ;
        endcase
    end

    hsj_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        cnt_next    = cnt_reg;
        phases_next = phases_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        bad_next    = bad_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    frame_next  = s_tdata;
                    phases_next = phases_c;
                    rem_next    = '0;
                    cnt_next    = '0;
                    px_next     = '0;
                    py_next     = '0;
                    nx_next     = '0;
                    ny_next     = '0;
                    bad_next    = (vp_width_reg == '0) || (vp_height_reg == '0);
                    if (bad_next || (phases_c == '0))
                        state_next = S_DONE;
                    else
                        state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                frame_next = {frame_reg[hsj_pkg::FRAME_W-3:0], 2'b00};
                rem_next   = rem_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == hsj_pkg::MOD_CNT_W'(hsj_pkg::MOD_STEPS - 1))
                begin
                    t_next     = idx_c;
                    px_next    = px_c;
                    num_next   = '0;
                    den_next   = hsj_pkg::NUM3_W'(1);
                    state_next = S_DIG;
                end
            end
            S_DIG:
            begin
                if (t_reg == '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_RI3;
                end
                else
                begin
                    t_next   = t_div3;
                    num_next = hsj_pkg::NUM3_W'({num_reg, 1'b0} + num_reg + digit);
                    den_next = hsj_pkg::NUM3_W'({den_reg, 1'b0} + den_reg);
                end
            end
            S_RI3:
            begin
                if (div_stat.done)
                begin
                    // quotient carries two extra fraction bits
                    py_next    = {~div_q[hsj_pkg::DIV_Q_W-1], div_q[hsj_pkg::DIV_Q_W-2:2]};
                    div_start  = 1'b1;
                    state_next = S_NX;
                end
            end
            S_NX:
            begin
                if (div_stat.done)
                begin
                    nx_next    = px_reg[hsj_pkg::PIX_W-1] ? (hsj_pkg::NDC_W'(0) - div_q) : div_q;
                    div_start  = 1'b1;
                    state_next = S_NY;
                end
            end
            S_NY:
            begin
                if (div_stat.done)
                begin
                    // vertical offset is negated
                    ny_next    = py_reg[hsj_pkg::PIX_W-1] ? div_q : (hsj_pkg::NDC_W'(0) - div_q);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        phases_reg <= phases_next;
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        bad_reg    <= bad_next;
        if (out_load)
        begin
            o_px_reg  <= px_reg;
            o_py_reg  <= py_reg;
            o_nx_reg  <= nx_reg;
            o_ny_reg  <= ny_reg;
            o_bad_reg <= bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, o_ny_reg, o_nx_reg, o_py_reg, o_px_reg};
    assign m_tuser  = o_bad_reg;

    // ---------------- assertions ----------------
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("bad viewport result carries nonzero data");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_mod_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (rem_reg < phases_reg))
        else $error("modulo remainder out of range");

endmodule

`default_nettype wire

>>> dv/halton_subpixel_jitter_checker.sv
// Checker for halton_subpixel_jitter: follows the register writes, predicts the
// jitter of each accepted request and compares it with the result stream.
// Depends on hsj_pkg.
`timescale 1ns / 1ps

module halton_subpixel_jitter_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [63:0] frame_index
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [15:0] pixel_x, [31:16] pixel_y, [49:32] ndc_x, [67:50] ndc_y
    input  wire logic [71:0] m_tdata,
    // [0] bad_viewport
    input  wire logic [0:0]  m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending
);

    localparam longint HALF_UNIT = 32768;
    localparam int PY_LSB = hsj_pkg::PIX_W;
    localparam int NX_LSB = 2 * hsj_pkg::PIX_W;
    localparam int NY_LSB = 2 * hsj_pkg::PIX_W + hsj_pkg::NDC_W;

    typedef struct packed {
        logic [hsj_pkg::PIX_W-1:0] pixel_x;
        logic [hsj_pkg::PIX_W-1:0] pixel_y;
        logic [hsj_pkg::NDC_W-1:0] ndc_x;
        logic [hsj_pkg::NDC_W-1:0] ndc_y;
        logic                      bad_viewport;
    } jitter_t;

    logic [hsj_pkg::PHASE_W-1:0] phase_cfg;
    logic [hsj_pkg::DIM_W-1:0]   width_cfg;
    logic [hsj_pkg::DIM_W-1:0]   height_cfg;
    jitter_t                     expected_jitter[$];

    // exact radical inverse, truncated to 16 fraction bits
    function automatic longint unsigned radical_inverse_q16(input longint unsigned idx,
                                                            input longint unsigned base);
        longint unsigned num;
        longint unsigned den;
        longint unsigned rest;
        num  = 0;
        den  = 1;
        rest = idx;
        while (rest > 0)
        begin
            num  = num * base + rest % base;
            den  = den * base;
            rest = rest / base;
        end
        return (num << 16) / den;
    endfunction

    function automatic jitter_t predict_jitter(input logic [63:0] frame);
        jitter_t         res;
        longint unsigned phases;
        longint unsigned idx;
        longint          px;
        longint          py;
        longint          nx;
        longint          ny;
        res    = '0;
        phases = (phase_cfg > hsj_pkg::MAX_PHASES) ? hsj_pkg::MAX_PHASES : phase_cfg;
        if (width_cfg == 0 || height_cfg == 0)
        begin
            res.bad_viewport = 1'b1;
        end
        else if (phases != 0)
        begin
            idx = frame % phases + 1;
            px  = longint'(radical_inverse_q16(idx, 2)) - HALF_UNIT;
            py  = longint'(radical_inverse_q16(idx, 3)) - HALF_UNIT;
            // signed division truncates toward zero
            nx  = (px * 2) / longint'(width_cfg);
            ny  = -((py * 2) / longint'(height_cfg));
            res.pixel_x = px[hsj_pkg::PIX_W-1:0];
            res.pixel_y = py[hsj_pkg::PIX_W-1:0];
            res.ndc_x   = nx[hsj_pkg::NDC_W-1:0];
            res.ndc_y   = ny[hsj_pkg::NDC_W-1:0];
        end
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        jitter_t want;
        if (!rst_n)
        begin
            phase_cfg  = hsj_pkg::PHASE_RST;
            width_cfg  = hsj_pkg::WIDTH_RST;
            height_cfg = hsj_pkg::HEIGHT_RST;
            expected_jitter.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        hsj_pkg::REG_PHASE_COUNT: phase_cfg  = pwdata[hsj_pkg::PHASE_W-1:0];
                        hsj_pkg::REG_VP_WIDTH:    width_cfg  = pwdata[hsj_pkg::DIM_W-1:0];
                        hsj_pkg::REG_VP_HEIGHT:   height_cfg = pwdata[hsj_pkg::DIM_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[3:2])
                        hsj_pkg::REG_PHASE_COUNT:
                            check_field("phase_count", phase_cfg, prdata);
                        hsj_pkg::REG_VP_WIDTH:
                            check_field("viewport_width", width_cfg, prdata);
                        hsj_pkg::REG_VP_HEIGHT:
                            check_field("viewport_height", height_cfg, prdata);
                        default: ;
                    endcase
                end
            end

            if (s_tvalid && s_tready)
                expected_jitter.push_back(predict_jitter(s_tdata));

            if (m_tvalid && m_tready)
            begin
                if (expected_jitter.size() == 0)
                begin
                    $error("result with no request outstanding: m_tdata=%h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_jitter.pop_front();
                    check_field("pixel_x", $signed(want.pixel_x),
                                $signed(m_tdata[PY_LSB-1:0]));
                    check_field("pixel_y", $signed(want.pixel_y),
                                $signed(m_tdata[NX_LSB-1:PY_LSB]));
                    check_field("ndc_x", $signed(want.ndc_x),
                                $signed(m_tdata[NY_LSB-1:NX_LSB]));
                    check_field("ndc_y", $signed(want.ndc_y),
                                $signed(m_tdata[NY_LSB+hsj_pkg::NDC_W-1:NY_LSB]));
                    check_field("bad_viewport", want.bad_viewport, m_tuser[0]);
                end
            end

            pending = expected_jitter.size();
        end
    end

endmodule

>>> dv/halton_subpixel_jitter_tb.sv
// Top of the halton_subpixel_jitter testbench: clock, reset, APB setup, frame
// requests and a result sink with random stalls; the checker does the comparing.
// Depends on hsj_pkg, halton_subpixel_jitter and halton_subpixel_jitter_checker.
`timescale 1ns / 1ps

module halton_subpixel_jitter_tb;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_IDLE       = 15;
    // long sink stall: block finishes one request, parks it, takes another, then stalls
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 53;
    // one address above the register map; writes there must change nothing
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;

    // stretch controls: calm = no idle cycles on that side
    bit tx_calm;
    bit rx_calm;
    bit rx_hold_req;

    halton_subpixel_jitter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    halton_subpixel_jitter_checker jitter_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Phase count: mostly in range, sometimes zero or above MAX_PHASES.
    // Unused upper pwdata bits carry noise; the block must drop them.
    function automatic logic [31:0] pick_phase_count();
        logic [31:0] noise;
        noise = $urandom & 32'hFFFF_FE00;
        case ($urandom_range(0, 9))
            0:       return noise;
            1:       return noise | 32'd256;
            2:       return noise | 32'd511;
            3:       return $urandom;
            4, 5:    return noise | $urandom_range(1, 16);
            default: return noise | $urandom_range(1, 256);
        endcase
    endfunction

    // Viewport size: zero now and then, 1, the top of the field, the upper half of the field.
    function automatic logic [31:0] pick_dimension();
        logic [31:0] noise;
        noise = $urandom & 32'hFFFF_8000;
        case ($urandom_range(0, 11))
            0:       return noise;
            1:       return noise | 32'd1;
            2:       return noise | 32'd32767;
            3:       return noise | $urandom_range(16385, 32767);
            default: return noise | $urandom_range(1, 16384);
        endcase
    endfunction

    // One APB transfer: setup then access, followed by an idle phase with psel low.
    // Called and returns on a falling edge.
    task automatic apb_access(input bit write, input logic [1:0] reg_idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Register updates only with nothing in flight; each value is read back.
    task automatic configure(input logic [31:0] phase_val, input logic [31:0] width_val,
                             input logic [31:0] height_val);
        while (pending != 0)
            @(negedge clk);
        apb_access(1'b1, hsj_pkg::REG_PHASE_COUNT, phase_val);
        apb_access(1'b1, hsj_pkg::REG_VP_WIDTH, width_val);
        apb_access(1'b1, hsj_pkg::REG_VP_HEIGHT, height_val);
        apb_access(1'b0, hsj_pkg::REG_PHASE_COUNT, '0);
        apb_access(1'b0, hsj_pkg::REG_VP_WIDTH, '0);
        apb_access(1'b0, hsj_pkg::REG_VP_HEIGHT, '0);
    endtask

    // Offer one request and hold it until taken. tvalid stays high into the
    // next request when no gap is drawn.
    task automatic send_frame(input logic [63:0] frame);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop tvalid and move one step on, so the next raise is in a later step.
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Mix of running frame counters (the normal use), raw 64-bit noise and
    // small indexes.
    task automatic random_burst(input int count);
        logic [63:0] running;
        logic [63:0] frame;
        int unsigned pick;
        running = {$urandom, $urandom};
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                frame = {$urandom, $urandom};
            end
            else if (pick < 7)
            begin
                frame   = running;
                running = running + 1;
            end
            else
            begin
                frame = $urandom_range(0, 1023);
            end
            send_frame(frame);
        end
        end_burst();
    endtask

    // Result sink: random stall per result, plus one long hold on request.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, then every phase of the default 8-phase cycle and two extreme frame indexes
        apb_access(1'b0, hsj_pkg::REG_PHASE_COUNT, '0);
        apb_access(1'b0, hsj_pkg::REG_VP_WIDTH, '0);
        apb_access(1'b0, hsj_pkg::REG_VP_HEIGHT, '0);
        for (int k = 0; k < 8; k++)
            send_frame(64'(k));
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h8000_0000_0000_0000);
        end_burst();

        // jitter disabled
        configure(32'd0, 32'd1920, 32'd1080);
        send_frame(64'd5);
        end_burst();

        // empty viewport wins over a zero phase count
        configure(32'd0, 32'd0, 32'd1080);
        send_frame(64'd3);
        end_burst();

        // phase count above MAX_PHASES saturates; 1x1 viewport gives the widest NDC
        configure(32'd511, 32'd1, 32'd1);
        send_frame(64'd255);
        send_frame(64'd127);
        send_frame(64'd0);
        end_burst();

        // full cycle, largest dimensions the field holds
        configure(32'd256, 32'd32767, 32'd32767);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'd511);
        end_burst();

        // zero height only
        configure(32'd256, 32'd16384, 32'd0);
        send_frame(64'd200);
        end_burst();

        // one phase: index is always 1, so the x jitter is zero
        configure(32'd1, 32'd1920, 32'd1080);
        send_frame({$urandom, $urandom});
        end_burst();

        // write past the register map, which must leave the registers alone
        configure(32'd3, 32'd4096, 32'd3);
        apb_access(1'b1, REG_UNMAPPED, $urandom);
        send_frame(64'd2);
        send_frame(64'd4);
        end_burst();

        // random phases; one with a long sink hold against a flat-out source,
        // one with no idling on either side
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            tx_calm = (p == 3 || p == 6);
            rx_calm = (p == 6);
            configure(pick_phase_count(), pick_dimension(), pick_dimension());
            if (p == 3)
                rx_hold_req = 1'b1;
            random_burst(PHASE_REQUESTS);
        end

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> halton_subpixel_jitter.f
rtl/hsj_pkg.sv
rtl/hsj_div.sv
rtl/halton_subpixel_jitter.sv
dv/halton_subpixel_jitter_checker.sv
dv/halton_subpixel_jitter_tb.sv
